/* hw/rtl/dcwe_pkg.sv */
// Shared constants, types and a helper function of the DDS command word encoder.
package dcwe_pkg;

  // Field widths.
  localparam int ReqW   = 3;
  localparam int FreqW  = 32;
  localparam int MclkW  = 26;
  localparam int TwW    = 28;
  localparam int HalfW  = 14;
  localparam int WordW  = 16;

  // The divider consumes every frequency bit, then one zero bit for each kept quotient bit.
  localparam int DivSteps = FreqW + TwW;
  localparam int StepCntW = $clog2(DivSteps);

  // Reset values.
  localparam logic [WordW-1:0] CtrlResetVal = 16'h2000;
  localparam logic [MclkW-1:0] MclkResetVal = 26'd25000000;

  // Control word bit masks.
  localparam logic [WordW-1:0] CtrlBitReset    = 16'h0100;
  localparam logic [WordW-1:0] CtrlBitSquare   = 16'h0020;
  localparam logic [WordW-1:0] CtrlBitTriangle = 16'h0002;

  // Frame tag of a frequency data frame: bit 15 clear, bit 14 set.
  localparam logic [1:0] DataTag = 2'b01;

  // Command codes.
  typedef enum logic [ReqW-1:0] {
    REQ_SINE      = 3'd0,
    REQ_TRIANGLE  = 3'd1,
    REQ_SQUARE    = 3'd2,
    REQ_RESET_ON  = 3'd3,
    REQ_RESET_OFF = 3'd4,
    REQ_SET_FREQ  = 3'd5
  } req_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CW,
    ST_LO,
    ST_HI
  } seq_state_t;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [FreqW-1:0] dividend;
    logic [MclkW-1:0] divisor;
  } div_req_t;

  // Response of the serial divider.
  typedef struct packed {
    logic           done;
    logic [TwW-1:0] quotient;
  } div_rsp_t;

  // Builds a frequency data frame from one 14-bit half of the tuning word.
  function automatic logic [WordW-1:0] data_frame(input logic [HalfW-1:0] half);
    return {DataTag, half};
  endfunction

endpackage

/* hw/rtl/dcwe_in_if.sv */
// Command channel interface: valid/ready handshake with command type and frequency.
interface dcwe_in_if;
  import dcwe_pkg::*;

  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [FreqW-1:0] freq_hz;

  modport source (output valid, output req_type, output freq_hz, input ready);
  modport sink   (input valid, input req_type, input freq_hz, output ready);
endinterface

/* hw/rtl/dcwe_out_if.sv */
// Frame channel interface: valid/ready handshake with frame word and last flag.
interface dcwe_out_if;
  import dcwe_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] frame_word;
  logic             last_word;

  modport source (output valid, output frame_word, output last_word, input ready);
  modport sink   (input valid, input frame_word, input last_word, output ready);
endinterface

/* hw/rtl/dcwe_div.sv */
// Bit-serial restoring divider that yields the low quotient bits of (dividend << 28) / divisor.
module dcwe_div
  import dcwe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [StepCntW-1:0] cnt_r, cnt_nxt;
  logic [FreqW-1:0]    num_r, num_nxt;
  logic [MclkW-1:0]    rem_r, rem_nxt;
  logic [MclkW-1:0]    den_r, den_nxt;
  logic [TwW-1:0]      quo_r, quo_nxt;

  logic [MclkW:0]      trial;
  logic [MclkW:0]      diff;
  logic                fits;

  // One quotient bit per cycle: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, num_r[FreqW-1]};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  // Step control and datapath update.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      num_nxt = {num_r[FreqW-2:0], 1'b0};
      rem_nxt = fits ? diff[MclkW-1:0] : trial[MclkW-1:0];
      quo_nxt = {quo_r[TwW-2:0], fits};
      cnt_nxt = cnt_r + StepCntW'(1);
      if (cnt_r == StepCntW'(DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* hw/rtl/dcwe_seq.sv */
// Command sequencer: holds the control word, starts divisions and drives the frame register.
module dcwe_seq
  import dcwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MclkW-1:0] divisor,
  dcwe_in_if.sink          in_chan,
  dcwe_out_if.source       out_chan,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp
);

  seq_state_t       state_r, state_nxt;
  logic [WordW-1:0] ctrl_r, ctrl_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WordW-1:0] out_word_r;
  logic             out_last_r;

  logic             load_ok;
  logic             load;
  logic [WordW-1:0] load_word;
  logic             load_last;

  // The frame register can take a new frame when empty or when it drains this cycle.
  assign load_ok = !out_valid_r || out_chan.ready;

  // Next state, control word and frame load.
  always_comb begin
    state_nxt        = state_r;
    ctrl_nxt         = ctrl_r;
    in_chan.ready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_chan.freq_hz;
    div_req.divisor  = divisor;
    load             = 1'b0;
    load_word        = ctrl_r;
    load_last        = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          unique case (in_chan.req_type)
            REQ_SINE: begin
              ctrl_nxt  = ctrl_r & ~(CtrlBitTriangle | CtrlBitSquare);
              state_nxt = ST_CW;
            end
            REQ_TRIANGLE: begin
              ctrl_nxt  = (ctrl_r & ~CtrlBitSquare) | CtrlBitTriangle;
              state_nxt = ST_CW;
            end
            REQ_SQUARE: begin
              ctrl_nxt  = (ctrl_r & ~CtrlBitTriangle) | CtrlBitSquare;
              state_nxt = ST_CW;
            end
            REQ_RESET_ON: begin
              ctrl_nxt  = ctrl_r | CtrlBitReset;
              state_nxt = ST_CW;
            end
            REQ_RESET_OFF: begin
              ctrl_nxt  = ctrl_r & ~CtrlBitReset;
              state_nxt = ST_CW;
            end
            REQ_SET_FREQ: begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
            default: begin
              // Unknown commands are dropped without a frame.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_LO;
        end
      end
      ST_CW: begin
        if (load_ok) begin
          load      = 1'b1;
          load_word = ctrl_r;
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_LO: begin
        if (load_ok) begin
          load      = 1'b1;
          load_word = data_frame(div_rsp.quotient[HalfW-1:0]);
          load_last = 1'b0;
          state_nxt = ST_HI;
        end
      end
      ST_HI: begin
        if (load_ok) begin
          load      = 1'b1;
          load_word = data_frame(div_rsp.quotient[TwW-1:HalfW]);
          load_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Frame register valid flag.
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State, control word and valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctrl_r      <= CtrlResetVal;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= load_word;
      out_last_r <= load_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_word = out_word_r;
  assign out_chan.last_word  = out_last_r;

endmodule

/* hw/rtl/dds_command_word_encoder_unit.sv */
// Top level of the DDS command word encoder: master clock register, sequencer and divider.
//
//   Channel   Direction  Handshake           Contents
//   in_chan   input      valid/ready         req_type, freq_hz
//   out_chan  output     valid/ready         frame_word, last_word
//   cfg       input      cfg_we, no ready    cfg_wdata = master clock in hertz
//
// A waveform or reset command is accepted, then the control word is loaded as one frame.
// Set frequency is accepted, runs in the bit-serial divider (one quotient bit per cycle),
// waits for the divider's done flag, then loads the two frames, low half first.
// Reset (rst_n low, synchronous) sets the control word to 0x2000 and the master clock
// to 25000000. A stalled output holds the frame register and the sequencer; one finished
// frame may wait in the register while the next command is accepted.
module dds_command_word_encoder_unit
  import dcwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  dcwe_in_if.sink          in_chan,
  dcwe_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic [MclkW-1:0] cfg_wdata
);

  logic [MclkW-1:0] mclk_r, mclk_nxt;
  logic [MclkW-1:0] divisor;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // Master clock register.
  assign mclk_nxt = cfg_we ? cfg_wdata : mclk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mclk_r <= MclkResetVal;
    end else begin
      mclk_r <= mclk_nxt;
    end
  end

  // A zero master clock divides as one.
  assign divisor = (mclk_r == '0) ? MclkW'(1) : mclk_r;

  dcwe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .divisor  (divisor),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  dcwe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule
